@@ rtl/core/mmr_pkg.sv @@
package mmr_pkg;

    // Default store depth and time width.
    localparam int MMR_MAX_MEETINGS = 64;
    localparam int MMR_TIME_BITS    = 16;

    // Width of the result count and its saturation value.
    localparam int ROOMS_BITS = 7;
    localparam int ROOMS_MAX  = 127;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_I,
        ST_LATCH_I,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clr_i;
        logic rd_i;
        logic latch_i;
        logic scan;
        logic update;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_j;
        logic last_i;
    } status_t;

endpackage

@@ rtl/core/min_meeting_rooms.sv @@
// Loading: an item is taken whenever start is high while the block is idle; on the last
// item the block goes busy and scans every pair of the meetings stored before the result word appears.
// Throughput: one item per cycle while loading and busy is low; the pairwise scan over the
// single-read-port start and end stores sets the per-set time.
// Reset (rst_n, async, active low) empties the set; the result cannot be stalled.
module min_meeting_rooms
    import mmr_pkg::*;
#(
    parameter int MAX_MEETINGS = MMR_MAX_MEETINGS,
    parameter int TIME_BITS    = MMR_TIME_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [TIME_BITS-1:0]  meeting_start,
    input  logic [TIME_BITS-1:0]  meeting_end,
    input  logic                  last_meeting,
    output logic                  done,
    output logic [ROOMS_BITS-1:0] rooms_needed,
    output logic                  overflowed
);

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    mmr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_meeting (last_meeting),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy)
    );

    // Stores, counters and compare logic.
    mmr_datapath #(
        .MAX_MEETINGS (MAX_MEETINGS),
        .TIME_BITS    (TIME_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .meeting_start (meeting_start),
        .meeting_end   (meeting_end),
        .status        (status),
        .done          (done),
        .rooms_needed  (rooms_needed),
        .overflowed    (overflowed)
    );

endmodule

@@ rtl/core/mmr_ram.sv @@
module mmr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/mmr_ctrl.sv @@
module mmr_ctrl
    import mmr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    last_meeting,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && last_meeting)
                begin
                    state_next = ST_RD_I;
                end
            end
            ST_RD_I:    state_next = ST_LATCH_I;
            ST_LATCH_I: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (status.last_j)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:   state_next = ST_UPDATE;
            ST_UPDATE:  state_next = status.last_i ? ST_DONE : ST_RD_I;
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs decoded from the state.
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy      = 1'b0;
                cmd.load  = start;
                cmd.clr_i = start && last_meeting;
            end
            ST_RD_I:    cmd.rd_i    = 1'b1;
            ST_LATCH_I: cmd.latch_i = 1'b1;
            ST_SCAN:    cmd.scan    = 1'b1;
            ST_DRAIN:   cmd         = '0;
            ST_UPDATE:  cmd.update  = 1'b1;
            ST_DONE:    cmd.finish  = 1'b1;
            default:    cmd         = '0;
        endcase
    end

endmodule

@@ rtl/core/mmr_datapath.sv @@
module mmr_datapath
    import mmr_pkg::*;
#(
    parameter int MAX_MEETINGS = MMR_MAX_MEETINGS,
    parameter int TIME_BITS    = MMR_TIME_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [TIME_BITS-1:0]  meeting_start,
    input  logic [TIME_BITS-1:0]  meeting_end,
    output status_t               status,
    output logic                  done,
    output logic [ROOMS_BITS-1:0] rooms_needed,
    output logic                  overflowed
);

    localparam int AW = $clog2(MAX_MEETINGS);
    localparam int CW = $clog2(MAX_MEETINGS + 1);

    logic [CW-1:0]         count_reg;
    logic                  ovf_reg;
    logic [AW-1:0]         i_reg;
    logic [AW-1:0]         j_reg;
    logic [TIME_BITS-1:0]  si_reg;
    logic [TIME_BITS-1:0]  ei_reg;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         peak_reg;
    logic                  jv_reg;
    logic [AW-1:0]         jd_reg;
    logic                  done_reg;
    logic [ROOMS_BITS-1:0] rooms_reg;
    logic                  ovf_out_reg;

    logic                  room_free;
    logic                  we;
    logic [AW-1:0]         raddr;
    logic [TIME_BITS-1:0]  sj;
    logic [TIME_BITS-1:0]  ej;
    logic                  goes_first;
    logic                  overlaps;
    logic [CW-1:0]         cand;
    logic [31:0]           peak_ext;

    // Meetings are stored in arrival order while space remains.
    assign room_free = count_reg < CW'(MAX_MEETINGS);
    assign we        = cmd.load && room_free;
    assign raddr     = cmd.rd_i ? i_reg : j_reg;

    mmr_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_MEETINGS)) u_start_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (meeting_start),
        .raddr (raddr),
        .rdata (sj)
    );

    mmr_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_MEETINGS)) u_end_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (meeting_end),
        .raddr (raddr),
        .rdata (ej)
    );

    // Meeting j precedes meeting i in start order, ties by end, then arrival.
    assign goes_first = (sj < si_reg) ||
                        ((sj == si_reg) && ((ej < ei_reg) ||
                                            ((ej == ei_reg) && (jd_reg < i_reg))));
    // A preceding meeting still holds its room when meeting i starts.
    assign overlaps = goes_first && (ej > si_reg);

    assign cand     = cnt_reg + CW'(1);
    assign peak_ext = 32'(peak_reg);

    assign status.last_j = CW'(j_reg) == count_reg - CW'(1);
    assign status.last_i = CW'(i_reg) == count_reg - CW'(1);

    // Load, scan and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            si_reg      <= '0;
            ei_reg      <= '0;
            cnt_reg     <= '0;
            peak_reg    <= '0;
            jv_reg      <= 1'b0;
            jd_reg      <= '0;
            done_reg    <= 1'b0;
            rooms_reg   <= '0;
            ovf_out_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            jv_reg   <= cmd.scan;
            jd_reg   <= j_reg;
            if (cmd.load)
            begin
                if (room_free)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.clr_i)
            begin
                i_reg    <= '0;
                peak_reg <= '0;
            end
            if (cmd.latch_i)
            begin
                si_reg  <= sj;
                ei_reg  <= ej;
                j_reg   <= '0;
                cnt_reg <= '0;
            end
            if (cmd.scan)
            begin
                j_reg <= j_reg + AW'(1);
            end
            if (jv_reg && overlaps)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.update)
            begin
                if (cand > peak_reg)
                begin
                    peak_reg <= cand;
                end
                i_reg <= i_reg + AW'(1);
            end
            if (cmd.finish)
            begin
                rooms_reg   <= (peak_ext > 32'(ROOMS_MAX)) ? ROOMS_BITS'(ROOMS_MAX)
                                                           : peak_ext[ROOMS_BITS-1:0];
                ovf_out_reg <= ovf_reg;
                count_reg   <= '0;
                ovf_reg     <= 1'b0;
            end
        end
    end

    assign done         = done_reg;
    assign rooms_needed = rooms_reg;
    assign overflowed   = ovf_out_reg;

    // The store count never passes the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_MEETINGS))
        else $error("meeting count beyond store depth");

    // A result word lasts exactly one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held");

    // The overlap count of a meeting stays below the number stored.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> cnt_reg < count_reg)
        else $error("overlap count too large");

endmodule

@@ tb/testbench.sv @@
module testbench
    import mmr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP       = MMR_MAX_MEETINGS;
    localparam int TB        = MMR_TIME_BITS;
    localparam int WDOG_MAX  = 200000;
    localparam int N_RANDOM  = 1070;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic [TB-1:0]   meeting_start;
    logic [TB-1:0]   meeting_end;
    logic            last_meeting;
    logic            done;
    logic [ROOMS_BITS-1:0] rooms_needed;
    logic            overflowed;

    min_meeting_rooms uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .meeting_start(meeting_start), .meeting_end(meeting_end),
        .last_meeting(last_meeting), .done(done),
        .rooms_needed(rooms_needed), .overflowed(overflowed)
    );

    // Expected result word of one set.
    typedef struct packed {
        logic [ROOMS_BITS-1:0] rooms;
        logic                  ovf;
    } rooms_word_t;

    // One row of the directed table; has_known marks a typed-in answer.
    typedef struct {
        logic [TB-1:0] s;
        logic [TB-1:0] e;
        logic          last;
        logic          has_known;
        rooms_word_t   known;
    } stim_row_t;

    rooms_word_t   pending_rooms[$];
    logic [TB-1:0] set_starts[$];
    logic [TB-1:0] set_ends[$];
    logic          set_ovf;
    int            errors;
    int            idle_cycles;
    stim_row_t     rows[$];

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Peak of overlapping meetings: sort by start, then end, stable; a meeting
    // ending at t frees its room for one starting at t.
    function automatic int peak_overlap();
        logic [TB-1:0] ss[$];
        logic [TB-1:0] ee[$];
        logic [TB-1:0] live[$];
        logic [TB-1:0] ts;
        logic [TB-1:0] te;
        int j;
        int peak;
        ss = set_starts;
        ee = set_ends;
        peak = 0;
        for (int i = 1; i < ss.size(); i++)
        begin
            ts = ss[i];
            te = ee[i];
            j = i;
            while (j > 0 && (ts < ss[j-1] || (ts == ss[j-1] && te < ee[j-1])))
            begin
                ss[j] = ss[j-1];
                ee[j] = ee[j-1];
                j--;
            end
            ss[j] = ts;
            ee[j] = te;
        end
        for (int i = 0; i < ss.size(); i++)
        begin
            live.sort();
            while (live.size() > 0 && ss[i] >= live[0])
                void'(live.pop_front());
            live.push_back(ee[i]);
            if (live.size() > peak)
                peak = live.size();
        end
        return peak;
    endfunction

    // Track one accepted word and predict the result on the last one.
    function automatic void note_meeting(logic [TB-1:0] s, logic [TB-1:0] e, logic last);
        rooms_word_t w;
        int p;
        if (set_starts.size() < CAP)
        begin
            set_starts.push_back(s);
            set_ends.push_back(e);
        end
        else
            set_ovf = 1'b1;
        if (last)
        begin
            p = peak_overlap();
            w.rooms = (p > ROOMS_MAX) ? ROOMS_MAX[ROOMS_BITS-1:0] : p[ROOMS_BITS-1:0];
            w.ovf = set_ovf;
            pending_rooms.push_back(w);
            set_starts.delete();
            set_ends.delete();
            set_ovf = 1'b0;
        end
    endfunction

    // Send one word after a random gap, waiting for the block to be free.
    // Start stays high on return so that a word with no gap follows at once.
    task automatic send_meeting(logic [TB-1:0] s, logic [TB-1:0] e, logic last);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        meeting_start <= s;
        meeting_end <= e;
        last_meeting <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        note_meeting(s, e, last);
        @(negedge clk);
    endtask

    function automatic void add_row(logic [TB-1:0] s, logic [TB-1:0] e, logic last,
                                    logic hk, int r, logic o);
        stim_row_t row;
        row.s = s;
        row.e = e;
        row.last = last;
        row.has_known = hk;
        row.known.rooms = r[ROOMS_BITS-1:0];
        row.known.ovf = o;
        rows.push_back(row);
    endfunction

    // Result checking and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_rooms.size() == 0)
                begin
                    $display("%0t: unexpected result rooms=%0d ovf=%0b",
                             $realtime, rooms_needed, overflowed);
                    errors++;
                end
                else
                begin
                    if (rooms_needed !== pending_rooms[0].rooms)
                    begin
                        $display("%0t: rooms_needed expected %0d actual %0d",
                                 $realtime, pending_rooms[0].rooms, rooms_needed);
                        errors++;
                    end
                    if (overflowed !== pending_rooms[0].ovf)
                    begin
                        $display("%0t: overflowed expected %0b actual %0b",
                                 $realtime, pending_rooms[0].ovf, overflowed);
                        errors++;
                    end
                    void'(pending_rooms.pop_front());
                end
            end
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("FAIL min_meeting_rooms");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int span;
        logic [TB-1:0] s;
        logic [TB-1:0] len;
        errors = 0;
        idle_cycles = 0;
        set_ovf = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        meeting_start = '0;
        meeting_end = '0;
        last_meeting = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed table: single meetings at the extremes, touching, equal
        // starts with a zero-length meeting, three nested meetings, end before start.
        add_row(16'h0000, 16'h0000, 1'b1, 1'b1, 1, 1'b0);
        add_row(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1, 1'b0);
        add_row(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1, 1'b0);
        add_row(16'h0000, 16'h0010, 1'b0, 1'b0, 0, 1'b0);
        add_row(16'h0010, 16'h0020, 1'b1, 1'b1, 1, 1'b0);
        add_row(16'h0005, 16'h0005, 1'b0, 1'b0, 0, 1'b0);
        add_row(16'h0005, 16'h0009, 1'b1, 1'b1, 1, 1'b0);
        add_row(16'h0000, 16'hFFFF, 1'b0, 1'b0, 0, 1'b0);
        add_row(16'h0001, 16'hFFFE, 1'b0, 1'b0, 0, 1'b0);
        add_row(16'h0002, 16'h0003, 1'b1, 1'b1, 3, 1'b0);
        add_row(16'h0100, 16'h0050, 1'b0, 1'b0, 0, 1'b0);
        add_row(16'h0060, 16'h0200, 1'b1, 1'b0, 0, 1'b0);
        add_row(16'hAAAA, 16'h5555, 1'b0, 1'b0, 0, 1'b0);
        add_row(16'h5555, 16'hAAAA, 1'b1, 1'b0, 0, 1'b0);
        foreach (rows[i])
        begin
            send_meeting(rows[i].s, rows[i].e, rows[i].last);
            if (rows[i].has_known && pending_rooms.size() > 0
                && pending_rooms[$] !== rows[i].known)
            begin
                $display("%0t: table row %0d expected %0d/%0b predicted %0d/%0b",
                         $realtime, i, rows[i].known.rooms, rows[i].known.ovf,
                         pending_rooms[$].rooms, pending_rooms[$].ovf);
                errors++;
            end
        end

        // Overflow: a full store plus extra words, all overlapping.
        for (int i = 0; i < CAP + 2; i++)
            send_meeting(i[TB-1:0], 16'hFFFF, i == CAP + 1);

        // Hold off until every expected word has arrived.
        start <= 1'b0;
        while (pending_rooms.size() > 0)
            @(negedge clk);

        // Random sets, mostly small, with a few near or over the store size.
        n = 0;
        while (n < N_RANDOM)
        begin
            int sz;
            case ($urandom_range(0, 9))
                0: sz = $urandom_range(CAP - 2, CAP + 3);
                1, 2: sz = 1;
                default: sz = $urandom_range(2, 12);
            endcase
            span = ($urandom_range(0, 1)) ? 64 : 65536;
            for (int k = 0; k < sz; k++)
            begin
                s = TB'($urandom_range(0, span - 1));
                case ($urandom_range(0, 7))
                    0: len = '0;
                    1: len = TB'($urandom());
                    default: len = TB'($urandom_range(0, span / 4));
                endcase
                send_meeting(s, ($urandom_range(0, 15) == 0) ? TB'($urandom()) : s + len,
                             k == sz - 1);
                n++;
            end
            if ($urandom_range(0, 40) == 0)
            begin
                start <= 1'b0;
                while (pending_rooms.size() > 0)
                    @(negedge clk);
            end
        end

        // Drain, then let the block settle.
        start <= 1'b0;
        while (pending_rooms.size() > 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0 && pending_rooms.size() == 0)
            $display("PASS min_meeting_rooms");
        else
            $display("FAIL min_meeting_rooms");
        $finish;
    end

endmodule

@@ min_meeting_rooms.f @@
rtl/core/mmr_pkg.sv
rtl/core/mmr_ram.sv
rtl/core/mmr_ctrl.sv
rtl/core/mmr_datapath.sv
rtl/core/min_meeting_rooms.sv
tb/testbench.sv
